### src/gvf_pkg.sv
// Shared types and constants of the GARCH(1,1) volatility filter.
`default_nettype none

package gvf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_OMEGA = 2'd0;
    localparam logic [1:0] REG_ALPHA = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;

    localparam logic [31:0] OMEGA_RST = 32'd10995116;
    localparam logic [23:0] ALPHA_RST = 24'd838861;
    localparam logic [23:0] BETA_RST  = 24'd15770583;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

    // Step counts of the iterative units
    localparam int DIV_INIT_STEPS = 72;
    localparam int DIV_STD_STEPS  = 48;
    localparam int SQRT_STEPS     = 32;
    localparam int CNT_W          = $clog2(DIV_INIT_STEPS);

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_SQ = 3'd0,
        MUL_AH = 3'd1,
        MUL_AL = 3'd2,
        MUL_BH = 3'd3,
        MUL_BL = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     init_zero;
        logic     div_load_init;
        logic     div_load_std;
        logic     div_step;
        logic     init_store;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add_hi;
        logic     acc_add_lo;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic params_bad;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### src/gvf_ctrl.sv
// Sequencer of the volatility filter: start-up, square root, divide, update.
`default_nettype none

module gvf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire gvf_pkg::stat_t stat,
    output gvf_pkg::cmd_t      cmd
);
    import gvf_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_INIT = 19'h00002,
        S_IDIV = 19'h00004,
        S_IEND = 19'h00008,
        S_SQLD = 19'h00010,
        S_SQ   = 19'h00020,
        S_DVLD = 19'h00040,
        S_DV   = 19'h00080,
        S_MSQ  = 19'h00100,
        S_SVSQ = 19'h00200,
        S_MAH  = 19'h00400,
        S_AAH  = 19'h00800,
        S_MAL  = 19'h01000,
        S_AAL  = 19'h02000,
        S_MBH  = 19'h04000,
        S_ABH  = 19'h08000,
        S_MBL  = 19'h10000,
        S_ABL  = 19'h20000,
        S_OUT  = 19'h40000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               started_reg, started_next;
    logic               cnt_zero;

    assign cnt_zero = (cnt_reg == '0);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_SQ;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = started_reg ? S_SQLD : S_INIT;
                end
            end
            S_INIT:
            begin
                started_next = 1'b1;
                if (stat.params_bad)
                begin
                    cmd.init_zero = 1'b1;
                    state_next    = S_SQLD;
                end
                else
                begin
                    cmd.div_load_init = 1'b1;
                    cnt_next          = CNT_W'(DIV_INIT_STEPS - 1);
                    state_next        = S_IDIV;
                end
            end
            S_IDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_zero)
                    state_next = S_IEND;
            end
            S_IEND:
            begin
                cmd.init_store = 1'b1;
                state_next     = S_SQLD;
            end
            S_SQLD:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = CNT_W'(SQRT_STEPS - 1);
                state_next    = S_SQ;
            end
            S_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_zero)
                    state_next = S_DVLD;
            end
            S_DVLD:
            begin
                cmd.div_load_std = 1'b1;
                cnt_next         = CNT_W'(DIV_STD_STEPS - 1);
                state_next       = S_DV;
            end
            S_DV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_zero)
                    state_next = S_MSQ;
            end
            S_MSQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SQ;
                state_next  = S_SVSQ;
            end
            S_SVSQ:
            begin
                cmd.acc_load = 1'b1;
                state_next   = S_MAH;
            end
            S_MAH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AH;
                state_next  = S_AAH;
            end
            S_AAH:
            begin
                cmd.acc_add_hi = 1'b1;
                state_next     = S_MAL;
            end
            S_MAL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AL;
                state_next  = S_AAL;
            end
            S_AAL:
            begin
                cmd.acc_add_lo = 1'b1;
                state_next     = S_MBH;
            end
            S_MBH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BH;
                state_next  = S_ABH;
            end
            S_ABH:
            begin
                cmd.acc_add_hi = 1'b1;
                state_next     = S_MBL;
            end
            S_MBL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BL;
                state_next  = S_ABL;
            end
            S_ABL:
            begin
                cmd.acc_add_lo = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

### src/gvf_datapath.sv
// Datapath of the volatility filter: registers, divider, square root, multiplier, output.
`default_nettype none

module gvf_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_write,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic [31:0]   return_value,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [31:0]        sigma_out,
    output logic [31:0]        std_return,
    output logic               params_invalid,
    input  wire gvf_pkg::cmd_t cmd,
    output gvf_pkg::stat_t     stat
);
    import gvf_pkg::*;

    // configuration and control state
    logic [31:0] omega_reg, omega_next;
    logic [23:0] alpha_reg, alpha_next;
    logic [23:0] beta_reg,  beta_next;
    logic [63:0] var_reg,   var_next;
    logic        bad_reg,   bad_next;
    logic        ovld_reg,  ovld_next;

    // payload
    logic [31:0] mag_reg,   mag_next;
    logic        neg_reg,   neg_next;
    logic [71:0] dvd_reg,   dvd_next;
    logic [71:0] quo_reg,   quo_next;
    logic [31:0] rem_reg,   rem_next;
    logic [31:0] dvs_reg,   dvs_next;
    logic [63:0] op_reg,    op_next;
    logic [63:0] res_reg,   res_next;
    logic [63:0] bit_reg,   bit_next;
    logic [63:0] prod_reg,  prod_next;
    logic [63:0] r2_reg,    r2_next;
    logic [63:0] acc_reg,   acc_next;
    logic [31:0] sig_o_reg, sig_o_next;
    logic [31:0] std_o_reg, std_o_next;
    logic        bad_o_reg, bad_o_next;

    logic [24:0] gain_sum;
    logic [24:0] init_dvs;
    logic [32:0] trial;
    logic        trial_ge;
    logic [63:0] sq_trial;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] addend;
    logic [64:0] acc_sum;
    logic [63:0] init_var;
    logic        q_big;
    logic [31:0] q_low;
    logic [31:0] std_val;

    assign gain_sum        = {1'b0, alpha_reg} + {1'b0, beta_reg};
    assign init_dvs        = ONE_Q24 - gain_sum;
    assign stat.params_bad = gain_sum[24];
    assign stat.out_free   = !ovld_reg || !out_stall;

    // restoring divider, one quotient bit a step
    assign trial    = {rem_reg, dvd_reg[71]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    assign sq_trial = res_reg + bit_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SQ:  begin mul_a = mag_reg;          mul_b = mag_reg;          end
            MUL_AH:  begin mul_a = {8'd0, alpha_reg}; mul_b = r2_reg[63:32];  end
            MUL_AL:  begin mul_a = {8'd0, alpha_reg}; mul_b = r2_reg[31:0];   end
            MUL_BH:  begin mul_a = {8'd0, beta_reg};  mul_b = var_reg[63:32]; end
            MUL_BL:  begin mul_a = {8'd0, beta_reg};  mul_b = var_reg[31:0];  end
            default: begin mul_a = '0;               mul_b = '0;               end
        endcase
    end

    // high half of a Q24 product moves up by 8, low half down by 24
    assign addend  = cmd.acc_add_hi ? {prod_reg[55:0], 8'd0} : {24'd0, prod_reg[63:24]};
    assign acc_sum = {1'b0, acc_reg} + {1'b0, addend};

    assign init_var = (quo_reg[71:64] != '0) ? '1 : quo_reg[63:0];

    assign q_big = (quo_reg[47:31] != '0);
    assign q_low = quo_reg[31:0];
    always_comb
    begin
        if (neg_reg)
            std_val = q_big ? 32'h8000_0000 : (~q_low + 32'd1);
        else
            std_val = q_big ? 32'h7FFF_FFFF : q_low;
    end

    always_comb
    begin
        omega_next = omega_reg;
        alpha_next = alpha_reg;
        beta_next  = beta_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_OMEGA: omega_next = cfg_data;
                REG_ALPHA: alpha_next = cfg_data[23:0];
                REG_BETA:  beta_next  = cfg_data[23:0];
                default:   ;
            endcase
        end

        var_next = var_reg;
        bad_next = bad_reg;
        if (cmd.init_zero)
        begin
            var_next = '0;
            bad_next = 1'b1;
        end
        else if (cmd.init_store)
        begin
            var_next = init_var;
            bad_next = 1'b0;
        end
        else if (cmd.out_load)
        begin
            var_next = acc_reg;
        end

        ovld_next = ovld_reg;
        if (cmd.out_load)
            ovld_next = 1'b1;
        else if (!out_stall)
            ovld_next = 1'b0;

        mag_next = mag_reg;
        neg_next = neg_reg;
        if (cmd.load_in)
        begin
            neg_next = return_value[31];
            mag_next = return_value[31] ? (~return_value + 32'd1) : return_value;
        end

        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (cmd.div_load_init || cmd.div_load_std)
        begin
            dvd_next = {cmd.div_load_init ? omega_reg : mag_reg, 40'd0};
            quo_next = '0;
            rem_next = '0;
            if (cmd.div_load_init)
                dvs_next = {7'd0, init_dvs};
            else
                dvs_next = (res_reg[31:0] != '0) ? res_reg[31:0] : ONE_Q28;
        end
        else if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[70:0], 1'b0};
            quo_next = {quo_reg[70:0], trial_ge};
            rem_next = trial_ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
        end

        op_next  = op_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (cmd.sqrt_load)
        begin
            op_next  = var_reg;
            res_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
        end
        else if (cmd.sqrt_step)
        begin
            if (op_reg >= sq_trial)
            begin
                op_next  = op_reg - sq_trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end

        prod_next = cmd.mul_en ? ({32'd0, mul_a} * {32'd0, mul_b}) : prod_reg;

        r2_next  = r2_reg;
        acc_next = acc_reg;
        if (cmd.acc_load)
        begin
            r2_next  = prod_reg;
            acc_next = {16'd0, omega_reg, 16'd0};
        end
        else if (cmd.acc_add_hi || cmd.acc_add_lo)
        begin
            // saturate on carry out
            acc_next = acc_sum[64] ? '1 : acc_sum[63:0];
        end

        sig_o_next = sig_o_reg;
        std_o_next = std_o_reg;
        bad_o_next = bad_o_reg;
        if (cmd.out_load)
        begin
            sig_o_next = res_reg[31:0];
            std_o_next = std_val;
            bad_o_next = bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg <= OMEGA_RST;
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            var_reg   <= '0;
            bad_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            omega_reg <= omega_next;
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
            var_reg   <= var_next;
            bad_reg   <= bad_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        op_reg    <= op_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        prod_reg  <= prod_next;
        r2_reg    <= r2_next;
        acc_reg   <= acc_next;
        sig_o_reg <= sig_o_next;
        std_o_reg <= std_o_next;
        bad_o_reg <= bad_o_next;
    end

    assign out_valid      = ovld_reg;
    assign sigma_out      = sig_o_reg;
    assign std_return     = std_o_reg;
    assign params_invalid = bad_o_reg;

endmodule

`default_nettype wire

### src/garch_volatility_filter.sv
// Top level of the GARCH(1,1) volatility filter.
`default_nettype none

// GARCH(1,1) filter over a stream of Q3.28 returns. Each return word gives one
// result word: sigma = floor(sqrt(h)) in Q4.28, the return divided by sigma
// in saturated Q15.16 (by 1.0 when sigma is zero), and the invalid-parameter
// flag. The variance h (Q8.56) then becomes omega + alpha*r^2 + beta*h with
// saturation. On the first word after reset h starts at omega/(1-alpha-beta)
// through a 72-step divide; if alpha+beta reaches one the flag is set and h
// starts at zero. One word is in flight at a time: the next is taken only once
// its result is loaded, and the first word after reset also waits for the
// start-up divide (skipped when the flag is raised). The 32-step bit-serial
// square root and shared radix-2 divider (48 steps) iterate; the update
// runs through a single 32x32 multiplier. The result sits in an output
// register, so the next word is accepted while a result still waits; a word
// that finishes while the previous result is still held waits in its last
// cycle until that result is taken. Write configuration only while idle.
module garch_volatility_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] return_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      sigma_out,
    output logic [31:0]      std_return,
    output logic             params_invalid
);
    import gvf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    gvf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .return_value   (return_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sigma_out      (sigma_out),
        .std_return     (std_return),
        .params_invalid (params_invalid),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire

### sim/garch_volatility_filter_test.sv
// Self-checking testbench of the GARCH(1,1) volatility filter, bit-true predictor and scoreboard.
`default_nettype none

module garch_volatility_filter_test;

    import gvf_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASES         = 8;
    localparam int         PHASE_WORDS    = 56;

    typedef struct packed {
        logic [31:0] sigma;
        logic [31:0] std_ret;
        logic        invalid;
    } filter_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] return_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sigma_out;
    logic [31:0] std_return;
    logic        params_invalid;

    // Register mirror and filter state of the predictor
    logic [31:0] omega_cfg;
    logic [23:0] alpha_cfg;
    logic [23:0] beta_cfg;
    logic [63:0] variance;
    logic        started;
    logic        bad_params;

    filter_result_t pending_results[$];
    int unsigned    errors = 0;
    int             burst_left = 1;
    int             idle_cycles = 0;

    garch_volatility_filter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .return_value   (return_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sigma_out      (sigma_out),
        .std_return     (std_return),
        .params_invalid (params_invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // floor(x * g / 2^24), clamped to 64 bits
    function automatic logic [63:0] scale_q24(input logic [63:0] x, input logic [23:0] g);
        logic [87:0] prod;
        prod = ({24'd0, x} * {64'd0, g}) >> 24;
        return (prod[87:64] != 24'd0) ? {64{1'b1}} : prod[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        int          i;
        root = 32'd0;
        for (i = 31; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= x)
                root = trial;
        end
        return {32'd0, root};
    endfunction

    function automatic filter_result_t predict_filter(input logic [31:0] r);
        logic [32:0]    mag;
        logic [24:0]    gain_sum;
        logic [71:0]    start_q;
        logic [63:0]    root;
        logic [63:0]    divisor;
        logic [63:0]    quot;
        logic [63:0]    r2;
        logic [63:0]    v;
        filter_result_t res;
        mag = r[31] ? (~{1'b1, r} + 33'd1) : {1'b0, r};
        // First word after reset: start from the long-run variance
        if (!started)
        begin
            gain_sum = {1'b0, alpha_cfg} + {1'b0, beta_cfg};
            if (gain_sum >= ONE_Q24)
            begin
                bad_params = 1'b1;
                variance   = 64'd0;
            end
            else
            begin
                bad_params = 1'b0;
                start_q    = {omega_cfg, 40'd0} / {47'd0, ONE_Q24 - gain_sum};
                variance   = (start_q[71:64] != 8'd0) ? {64{1'b1}} : start_q[63:0];
            end
            started = 1'b1;
        end
        root    = floor_sqrt(variance);
        divisor = (root != 64'd0) ? root : {32'd0, ONE_Q28};
        quot    = {15'd0, mag, 16'd0} / divisor;
        res.sigma = root[31:0];
        if (r[31])
            res.std_ret = (quot >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quot[31:0]);
        else
            res.std_ret = (quot >= 64'h8000_0000) ? 32'h7FFF_FFFF : quot[31:0];
        res.invalid = bad_params;
        r2 = {31'd0, mag} * {31'd0, mag};
        v  = {16'd0, omega_cfg, 16'd0};
        v  = add_sat(v, scale_q24(r2, alpha_cfg));
        v  = add_sat(v, scale_q24(variance, beta_cfg));
        variance = v;
        return res;
    endfunction

    function automatic logic [31:0] random_return();
        logic [31:0] mag;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            mag = $urandom_range(0, 1 << 20);
        else if (sel <= 7)
            return $urandom;
        else if (sel == 8)
            mag = $urandom_range(0, 1 << 27);
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h0000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return ($urandom_range(0, 1) != 0) ? (32'd0 - mag) : mag;
    endfunction

    // Called at a falling edge; leaves the write enable low again before returning
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_OMEGA: omega_cfg = data;
            REG_ALPHA: alpha_cfg = data[23:0];
            REG_BETA:  beta_cfg  = data[23:0];
            default:   ;
        endcase
    endtask

    // Called at a falling edge; hold the word until it is taken, then pace the burst
    task automatic send_return(input logic [31:0] r);
        int gap;
        in_valid     <= 1'b1;
        return_value <= r;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(), predict_filter(r));
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 30);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Drop valid, drain all results, let the update finish before touching registers
    task automatic await_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        while (in_stall)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_start_conditions();
        logic [31:0] om;
        logic [31:0] pick;
        logic [23:0] al;
        logic [23:0] be;
        logic [31:0] probes[7] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
                                  32'hFFF0_0000};
        case ($urandom_range(0, 3))
            0:
            begin
                om = OMEGA_RST;
                al = ALPHA_RST;
                be = BETA_RST;
            end
            1:
            begin
                // gains reach one: flag raised, variance starts at zero
                pick = $urandom_range(1, 32'h00FF_FFFF);
                al   = pick[23:0];
                pick = {7'd0, ONE_Q24} - {8'd0, al} + $urandom_range(0, 3);
                if (pick > 32'h00FF_FFFF)
                    pick = 32'h00FF_FFFF;
                be = pick[23:0];
                om = $urandom;
            end
            2:
            begin
                // one minus the gains is one LSB: start variance clamps
                om   = 32'hFFFF_FFFF - $urandom_range(0, 255);
                pick = $urandom_range(0, 32'h00FF_FFFF);
                al   = pick[23:0];
                be   = 24'hFF_FFFF - al;
            end
            default:
            begin
                pick = $urandom_range(0, 32'h00FF_FFFF);
                al   = pick[23:0];
                pick = $urandom_range(0, 32'h00FF_FFFF - {8'd0, al});
                be   = pick[23:0];
                om   = $urandom;
            end
        endcase
        write_reg(REG_OMEGA, om);
        write_reg(REG_ALPHA, {8'd0, al});
        write_reg(REG_BETA, {8'd0, be});
        write_reg(REG_SPARE, $urandom);
        foreach (probes[i])
            send_return(probes[i]);
    endtask

    // Variance collapses to zero, so the return passes through divided by one
    task automatic test_zero_sigma();
        logic [31:0] probes[5] = '{32'h0040_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_EFFF, 32'h0000_0FFF};
        await_idle();
        write_reg(REG_OMEGA, 32'd0);
        write_reg(REG_ALPHA, 32'd0);
        write_reg(REG_BETA, 32'd0);
        foreach (probes[i])
            send_return(probes[i]);
    endtask

    // Tiny sigma drives the quotient into both clamps
    task automatic test_quotient_clamp();
        logic [31:0] probes[6] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h0080_0000, 32'hFF80_0000, 32'h0000_0100};
        await_idle();
        write_reg(REG_OMEGA, 32'd1);
        write_reg(REG_ALPHA, 32'd0);
        write_reg(REG_BETA, 32'd0);
        foreach (probes[i])
            send_return(probes[i]);
    endtask

    task automatic test_saturation();
        logic [31:0] probes[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h1234_5678, 32'h0000_0000};
        await_idle();
        write_reg(REG_OMEGA, 32'hFFFF_FFFF);
        write_reg(REG_ALPHA, 32'h00FF_FFFF);
        write_reg(REG_BETA, 32'h00FF_FFFF);
        foreach (probes[i])
            send_return(probes[i]);
    endtask

    task automatic test_random_phases();
        int          phase;
        int          n;
        int          kind;
        logic [31:0] om;
        logic [31:0] pick;
        logic [23:0] al;
        logic [23:0] be;
        for (phase = 0; phase < PHASES; phase++)
        begin
            await_idle();
            kind = (phase == 0) ? -1 : $urandom_range(0, 3);
            case (kind)
                -1:
                begin
                    om = OMEGA_RST;
                    al = ALPHA_RST;
                    be = BETA_RST;
                end
                0:
                begin
                    // market-like gains, persistence just below one
                    om   = $urandom_range(0, 1 << 26);
                    pick = $urandom_range(0, 1 << 21);
                    al   = pick[23:0];
                    pick = 32'h00FF_FFFF - {8'd0, al} - $urandom_range(0, 1 << 20);
                    be   = pick[23:0];
                end
                1:
                begin
                    om   = $urandom;
                    pick = $urandom;
                    al   = pick[23:0];
                    pick = $urandom;
                    be   = pick[23:0];
                end
                2:
                begin
                    om = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
                    al = ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'd0;
                    be = ($urandom_range(0, 1) != 0) ? 24'hFF_FFFF : 24'd0;
                end
                default:
                begin
                    // explosive gains: variance climbs towards the clamp
                    om   = $urandom_range(0, 1 << 16);
                    pick = $urandom_range(1 << 23, 32'h00FF_FFFF);
                    al   = pick[23:0];
                    pick = $urandom_range(1 << 23, 32'h00FF_FFFF);
                    be   = pick[23:0];
                end
            endcase
            write_reg(REG_OMEGA, om);
            write_reg(REG_ALPHA, {8'd0, al});
            write_reg(REG_BETA, {8'd0, be});
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, $urandom);
            for (n = 0; n < PHASE_WORDS; n++)
                send_return(random_return());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_OMEGA;
        cfg_data     = 32'd0;
        in_valid     = 1'b0;
        return_value = 32'd0;
        omega_cfg    = OMEGA_RST;
        alpha_cfg    = ALPHA_RST;
        beta_cfg     = BETA_RST;
        variance     = 64'd0;
        started      = 1'b0;
        bad_params   = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_start_conditions();
        test_zero_sigma();
        test_quotient_clamp();
        test_saturation();
        test_random_phases();
        await_idle();
        if (errors == 0 && pending_results.size() == 0)
            $display("garch_volatility_filter: match");
        else
            $display("garch_volatility_filter: mismatch");
        $finish;
    end

    // Receiver stall pattern: free runs, random stalls and long holds
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 2))
                0:
                    repeat ($urandom_range(20, 300))
                    begin
                        @(negedge clk);
                        out_stall <= 1'b0;
                    end
                1:
                    repeat ($urandom_range(20, 300))
                    begin
                        @(negedge clk);
                        out_stall <= ($urandom_range(0, 1) != 0);
                    end
                default:
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 150)) @(negedge clk);
                end
            endcase
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        filter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none predicted, sigma %h std %h",
                         $time, sigma_out, std_return);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("sigma_out", want.sigma, sigma_out);
                check_field("std_return", want.std_ret, std_return);
                check_field("params_invalid", {31'd0, want.invalid}, {31'd0, params_invalid});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("garch_volatility_filter: mismatch");
            $finish;
        end
    end

endmodule

`default_nettype wire

### filelist.f
src/gvf_pkg.sv
src/gvf_ctrl.sv
src/gvf_datapath.sv
src/garch_volatility_filter.sv
sim/garch_volatility_filter_test.sv
